// File: rtl/srt_pkg.sv
package srt_pkg;

    // Field widths of the request and result transfers.
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int USAGE_W = 4;
    localparam int POS_W   = 6;
    localparam int GEN_W   = 32;

    // Command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    // Register word index of the configuration port.
    localparam logic REG_SHADER_USAGE = 1'b0;
    localparam logic [USAGE_W-1:0] SHADER_USAGE_RESET = 4'd1;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [USAGE_W-1:0] usage;
        logic               mark;
    } t_entry;

    // One accepted request.
    typedef struct packed {
        logic               command;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [USAGE_W-1:0] usage;
        logic               mark;
    } t_request;

    // One result item.
    typedef struct packed {
        logic               hit;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic [USAGE_W-1:0] usage;
        logic               mark;
        logic [GEN_W-1:0]   generation;
        logic               full;
    } t_result;

endpackage

// File: rtl/srt_entry_ram.sv
module srt_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  srt_pkg::t_entry     i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output srt_pkg::t_entry     o_rd_data
);
    import srt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, data in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/srt_ctrl.sv
module srt_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  srt_pkg::t_request           i_req,
    output logic                        o_req_ready,
    input  logic [srt_pkg::USAGE_W-1:0] i_shader_code,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  srt_pkg::t_entry             i_rd_data,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output srt_pkg::t_entry             o_wr_data,
    output logic                        o_res_valid,
    output srt_pkg::t_result            o_res,
    input  logic                        i_res_take
);
    import srt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_WRITE,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [GEN_W-1:0]   r_gen, n_gen;
    t_request           r_req, n_req;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [CW-1:0]      r_mid, n_mid;
    logic [CW-1:0]      r_idx, n_idx;
    t_entry             r_cand, n_cand;
    logic               r_found, n_found;
    t_result            r_res, n_res;

    logic [CW-1:0]      w_mid;
    logic               w_found;
    logic [CW+POS_W-1:0] w_pos_ext;
    logic [POS_W-1:0]   w_pos;
    t_entry             w_new;
    logic               w_bump;

    // Address of the entry below a shift cursor.
    function automatic logic [AW-1:0] n_idx_dec(input logic [CW-1:0] idx);
        logic [CW-1:0] below;
        below = idx - CW'(1);
        return below[AW-1:0];
    endfunction

    // Midpoint of the open search window and the outcome of the search.
    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_found   = (r_lo < r_count) && (r_cand.key == r_req.key);
    assign w_pos_ext = {{POS_W{1'b0}}, r_lo};
    assign w_pos     = w_pos_ext[POS_W-1:0];

    // Entry written on an insert or a value change; a change keeps the stored usage.
    always_comb begin
        w_new.key   = r_req.key;
        w_new.value = r_req.value;
        w_new.usage = r_found ? r_cand.usage : r_req.usage;
        w_new.mark  = r_req.mark;
        if (r_found) begin
            w_bump = (r_cand.usage == i_shader_code);
        end else begin
            w_bump = !r_req.mark && (r_req.usage == i_shader_code);
        end
    end

    // Sequencer: binary search, then shift and write back as needed.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_gen     = r_gen;
        n_req     = r_req;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_idx     = r_idx;
        n_cand    = r_cand;
        n_found   = r_found;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_mid[AW-1:0];
                    n_mid     = w_mid;
                    n_state   = S_SRCH_CMP;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_SRCH_CMP: begin
                // The last entry that closes the window from above is the candidate.
                if (i_rd_data.key < r_req.key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi   = r_mid;
                    n_cand = i_rd_data;
                end
                n_state = S_SRCH_RD;
            end
            S_DECIDE: begin
                n_found        = w_found;
                n_res.hit      = 1'b0;
                n_res.position = w_pos;
                n_res.value    = r_cand.value;
                n_res.usage    = r_cand.usage;
                n_res.mark     = r_cand.mark;
                n_res.generation = r_gen;
                n_res.full     = 1'b0;
                n_state        = S_DONE;
                if (r_req.command == CMD_LOOKUP) begin
                    n_res.hit = w_found;
                    if (!w_found) begin
                        n_res.value = '0;
                        n_res.usage = '0;
                        n_res.mark  = 1'b0;
                    end
                end else if (!w_found) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_res.full  = 1'b1;
                        n_res.value = '0;
                        n_res.usage = '0;
                        n_res.mark  = 1'b0;
                    end else begin
                        n_idx   = r_count;
                        n_state = S_SH_RD;
                    end
                end else if (r_cand.value != r_req.value) begin
                    n_state = S_WRITE;
                end
            end
            S_SH_RD: begin
                // Move entries above the insertion point up by one, top first.
                if (r_idx > r_lo) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = n_idx_dec(r_idx);
                    n_state   = S_SH_WR;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SH_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx[AW-1:0];
                o_wr_data = i_rd_data;
                n_idx     = r_idx - CW'(1);
                n_state   = S_SH_RD;
            end
            S_WRITE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_lo[AW-1:0];
                o_wr_data = w_new;
                if (!r_found) begin
                    n_count = r_count + CW'(1);
                end
                if (w_bump) begin
                    n_gen = r_gen + GEN_W'(1);
                end
                n_res.hit        = 1'b1;
                n_res.position   = w_pos;
                n_res.value      = w_new.value;
                n_res.usage      = w_new.usage;
                n_res.mark       = w_new.mark;
                n_res.generation = w_bump ? (r_gen + GEN_W'(1)) : r_gen;
                n_res.full       = 1'b0;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_gen   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_gen   <= n_gen;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_idx   <= n_idx;
        r_cand  <= n_cand;
        r_found <= n_found;
        r_res   <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: rtl/sorted_property_table.sv
// Sorted property table: keeps up to TABLE_DEPTH entries ordered by ascending
// key in one single-port-write, registered-read entry memory, and answers a
// lookup or a set for each request transfer with one result transfer. A
// request is accepted, then walks a binary search in which each halving
// step reads the midpoint entry and then compares its key, and ends with
// the closing window check, the decision and the hand-off; a value change
// adds a memory write, and an insert shifts every entry above the insertion
// point up one at a time by a read and a write of the memory, then does
// the closing shift check and writes the new entry.
// The result sits in an output register, so a new request is taken while the
// previous result still waits. The generation counter advances on changes to
// entries whose usage equals the shader usage register (byte address 0, reset
// 1); an insert that sets the overwritten mark leaves it unchanged. Entries
// are not cleared at reset; only the live ones are ever read.
module sorted_property_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [srt_pkg::KEY_W-1:0]   i_key,
    input  logic [srt_pkg::VALUE_W-1:0] i_value,
    input  logic [srt_pkg::USAGE_W-1:0] i_usage,
    input  logic                        i_mark_overwritten,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [srt_pkg::POS_W-1:0]   o_position,
    output logic [srt_pkg::VALUE_W-1:0] o_entry_value,
    output logic [srt_pkg::USAGE_W-1:0] o_entry_usage,
    output logic                        o_entry_overwritten,
    output logic [srt_pkg::GEN_W-1:0]   o_generation,
    output logic                        o_table_full,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import srt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [USAGE_W-1:0] r_shader_code;
    logic               w_cfg_write;
    logic               w_cfg_sel;

    t_request           w_req;
    logic               w_req_ready;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    t_entry             w_rd_data;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    t_entry             w_wr_data;
    logic               w_res_valid;
    t_result            w_res;
    logic               w_res_take;

    logic               r_out_valid;
    t_result            r_out;

    // Configuration register write and read-back.
    assign pready      = 1'b1;
    assign w_cfg_sel   = (paddr[2] == REG_SHADER_USAGE);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shader_code <= SHADER_USAGE_RESET;
        end else if (w_cfg_write && w_cfg_sel) begin
            r_shader_code <= pwdata[USAGE_W-1:0];
        end
    end

    assign prdata = w_cfg_sel ? {{(32-USAGE_W){1'b0}}, r_shader_code} : 32'd0;

    // Request transfer.
    assign w_req.command = i_command;
    assign w_req.key     = i_key;
    assign w_req.value   = i_value;
    assign w_req.usage   = i_usage;
    assign w_req.mark    = i_mark_overwritten;
    assign o_in_stall    = !w_req_ready;

    srt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_in_valid),
        .i_req         (w_req),
        .o_req_ready   (w_req_ready),
        .i_shader_code (r_shader_code),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_take    (w_res_take)
    );

    srt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: loads a finished result whenever it is empty or being drained.
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_hit               = r_out.hit;
    assign o_position          = r_out.position;
    assign o_entry_value       = r_out.value;
    assign o_entry_usage       = r_out.usage;
    assign o_entry_overwritten = r_out.mark;
    assign o_generation        = r_out.generation;
    assign o_table_full        = r_out.full;

endmodule
